@@ src/abm_pkg.sv @@
`timescale 1ns / 1ps

package abm_pkg;

   localparam int HdrLen   = 32;
   localparam int CrcSpan  = 28;
   localparam int IdxW     = 5;

   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
   localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_CHECK   = 3'd1;
   localparam logic [2:0] OP_MARK    = 3'd2;
   localparam logic [2:0] OP_ACTIVE  = 3'd3;
   localparam logic [2:0] OP_STABLE  = 3'd4;
   localparam logic [2:0] OP_DISABLE = 3'd5;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_INCOMPLETE   = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC    = 3'd2;
   localparam logic [2:0] ST_BAD_VERSION  = 3'd3;
   localparam logic [2:0] ST_BAD_CRC      = 3'd4;
   localparam logic [2:0] ST_NOT_BOOTABLE = 3'd5;

   localparam logic CSR_MAX_PRIORITY = 1'b0;
   localparam logic CSR_MAX_TRIES    = 1'b1;

   localparam logic [7:0] MAGIC_0     = 8'h41;
   localparam logic [7:0] MAGIC_1     = 8'h42;
   localparam logic [7:0] MAGIC_2     = 8'h30;
   localparam logic [7:0] HDR_VERSION = 8'd1;
   localparam logic [7:0] PRI_RESET   = 8'd15;
   localparam logic [7:0] TRIES_RESET = 8'd7;

   localparam int SlotAAt = 8;
   localparam int SlotBAt = 12;

   typedef struct packed {
      logic load;
      logic start;
      logic single;
      logic write_slots;
      logic crc_step;
      logic write_crc;
      logic emit;
   } abm_cmd_type;

   typedef struct packed {
      logic single_needed;
      logic crc_last;
      logic emit_last;
      logic out_free;
   } abm_stat_type;

endpackage

@@ src/ab_boot_slot_metadata_update.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                     Direction
// req       req_valid/req_stall, op, byte, slot       in
// rsp       rsp_valid/rsp_stall, byte, index, flags   out
// csr       csr_write_en, csr_index, csr_wdata        in, write only
//
// A load leaves the controller idle, so loads can follow one another. A command
// is accepted in the idle state and decided in the decide state; an error or
// check then gives its single item. An update walks the 28 CRC bytes one per
// cycle through the CRC unit, writes the CRC, then emits 32 items. Output
// stalls hold the emit sequencer and a pending single item.
// Reset is synchronous; the header store is not cleared.

module ab_boot_slot_metadata_update (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_data_byte,
   input  logic       req_target_slot,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [4:0] rsp_byte_index,
   output logic       rsp_last,
   output logic [2:0] rsp_status,
   output logic       rsp_slot_a_bootable,
   output logic       rsp_slot_b_bootable,
   output logic       rsp_slot_a_illegal,
   output logic       rsp_slot_b_illegal
);
   import abm_pkg::*;

   abm_cmd_type  cmd;
   abm_stat_type stat;

   abm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .stat          (stat)
   );

   abm_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_operation       (req_operation),
      .req_data_byte       (req_data_byte),
      .req_target_slot     (req_target_slot),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_slot_a_bootable (rsp_slot_a_bootable),
      .rsp_slot_b_bootable (rsp_slot_b_bootable),
      .rsp_slot_a_illegal  (rsp_slot_a_illegal),
      .rsp_slot_b_illegal  (rsp_slot_b_illegal)
   );

endmodule

@@ src/abm_datapath.sv @@
`timescale 1ns / 1ps

module abm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic                  csr_index,
   input  logic [7:0]            csr_wdata,
   input  logic [2:0]            req_operation,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_target_slot,
   input  abm_pkg::abm_cmd_type  cmd,
   output abm_pkg::abm_stat_type stat,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_byte,
   output logic [4:0]            rsp_byte_index,
   output logic                  rsp_last,
   output logic [2:0]            rsp_status,
   output logic                  rsp_slot_a_bootable,
   output logic                  rsp_slot_b_bootable,
   output logic                  rsp_slot_a_illegal,
   output logic                  rsp_slot_b_illegal
);
   import abm_pkg::*;

   typedef logic [3:0][7:0] slot_type;

   function automatic logic is_bootable(slot_type s);
      return (s[0] != 8'd0) && ((s[2] != 8'd0) || (s[1] != 8'd0));
   endfunction

   function automatic logic is_illegal(slot_type s);
      return (s[0] != 8'd0) && (s[1] != 8'd0) && (s[2] != 8'd0);
   endfunction

   function automatic logic is_kept(slot_type s);
      return (s[0] != 8'd0) && ((s[1] != 8'd0) != (s[2] != 8'd0));
   endfunction

   function automatic slot_type normalize(slot_type s);
      return is_kept(s) ? s : '0;
   endfunction

   function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [7:0]  hdr_ff [HdrLen];
   logic [7:0]  hdr_in [HdrLen];
   logic [5:0]  loaded_ff, loaded_in;
   logic [31:0] crc_ff, crc_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [7:0]  max_pri_ff, max_pri_in;
   logic [7:0]  max_tries_ff, max_tries_in;
   logic [2:0]  op_ff, op_in;
   logic        slot_ff, slot_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [4:0]  byte_index_ff, byte_index_in;
   logic        last_ff, last_in;
   logic [2:0]  status_ff, status_in;
   logic [3:0]  flags_ff, flags_in;

   slot_type    slot_a, slot_b, tgt_old, oth_old, tgt_new, oth_new, new_a, new_b;
   logic [7:0]  lowered;
   logic [31:0] stored_crc;
   logic [2:0]  cmd_status;
   logic [3:0]  cur_flags;
   logic [4:0]  load_at;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         slot_a[i] = hdr_ff[IdxW'(SlotAAt + i)];
         slot_b[i] = hdr_ff[IdxW'(SlotBAt + i)];
      end
   end

   assign cur_flags = {is_illegal(slot_b), is_illegal(slot_a),
                       is_bootable(slot_b), is_bootable(slot_a)};

   assign stored_crc = {hdr_ff[CrcSpan], hdr_ff[CrcSpan + 1],
                        hdr_ff[CrcSpan + 2], hdr_ff[CrcSpan + 3]};

   // slot update for set active / make stable / mark / disable
   always_comb begin
      tgt_old = slot_ff ? slot_b : slot_a;
      oth_old = slot_ff ? slot_a : slot_b;
      lowered = (max_pri_ff != 8'd0) ? (max_pri_ff - 8'd1) : 8'd0;
      tgt_new = normalize(tgt_old);
      oth_new = normalize(oth_old);
      unique case (op_ff)
         OP_DISABLE: begin
            tgt_new = '0;
            oth_new = oth_old;
         end
         OP_MARK: begin
            tgt_new[1] = 8'd0;
            tgt_new[2] = 8'd1;
            tgt_new[3] = 8'd0;
         end
         OP_ACTIVE: begin
            tgt_new = {8'd0, 8'd0, max_tries_ff, max_pri_ff};
            if (oth_new[0] == max_pri_ff) begin
               oth_new[0] = lowered;
            end
         end
         OP_STABLE: begin
            tgt_new = {8'd0, 8'd1, 8'd0, max_pri_ff};
            if (oth_new[0] >= max_pri_ff) begin
               oth_new[0] = lowered;
            end
         end
         default: begin
         end
      endcase
      new_a = slot_ff ? oth_new : tgt_new;
      new_b = slot_ff ? tgt_new : oth_new;
   end

   always_comb begin
      priority if (loaded_ff != 6'(HdrLen)) begin
         cmd_status = ST_INCOMPLETE;
      end else if (hdr_ff[1] != MAGIC_0 || hdr_ff[2] != MAGIC_1 || hdr_ff[3] != MAGIC_2) begin
         cmd_status = ST_BAD_MAGIC;
      end else if (hdr_ff[4] != HDR_VERSION) begin
         cmd_status = ST_BAD_VERSION;
      end else if (stored_crc != ~crc_ff) begin
         cmd_status = ST_BAD_CRC;
      end else if (op_ff == OP_MARK && !is_kept(tgt_old)) begin
         cmd_status = ST_NOT_BOOTABLE;
      end else begin
         cmd_status = ST_OK;
      end
   end

   assign stat.single_needed = (cmd_status != ST_OK) || (op_ff == OP_CHECK);
   assign stat.crc_last      = (idx_ff == IdxW'(CrcSpan - 1));
   assign stat.emit_last     = (idx_ff == IdxW'(HdrLen - 1));
   assign stat.out_free      = !rsp_valid_ff || !rsp_stall;

   assign load_at = loaded_ff[5] ? 5'd0 : loaded_ff[4:0];

   always_comb begin
      hdr_in        = hdr_ff;
      loaded_in     = loaded_ff;
      crc_in        = crc_ff;
      idx_in        = idx_ff;
      max_pri_in    = max_pri_ff;
      max_tries_in  = max_tries_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_byte_in   = out_byte_ff;
      byte_index_in = byte_index_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      flags_in      = flags_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_PRIORITY: max_pri_in   = csr_wdata;
            CSR_MAX_TRIES:    max_tries_in = csr_wdata;
         endcase
      end

      if (cmd.load) begin
         hdr_in[load_at] = req_data_byte;
         if (loaded_ff[5]) begin
            loaded_in = 6'd1;
            crc_in    = crc_byte(CRC_ONES, req_data_byte);
         end else begin
            loaded_in = loaded_ff + 6'd1;
            if (loaded_ff < 6'(CrcSpan)) begin
               crc_in = crc_byte(crc_ff, req_data_byte);
            end
         end
      end

      if (cmd.start) begin
         op_in   = req_operation;
         slot_in = req_target_slot;
      end

      if (cmd.write_slots) begin
         for (int i = 0; i < 4; i++) begin
            hdr_in[IdxW'(SlotAAt + i)] = new_a[i];
            hdr_in[IdxW'(SlotBAt + i)] = new_b[i];
         end
         idx_in = '0;
         crc_in = CRC_ONES;
      end

      if (cmd.crc_step) begin
         crc_in = crc_byte(crc_ff, hdr_ff[idx_ff]);
         idx_in = idx_ff + IdxW'(1);
      end

      if (cmd.write_crc) begin
         hdr_in[CrcSpan]     = ~crc_ff[31:24];
         hdr_in[CrcSpan + 1] = ~crc_ff[23:16];
         hdr_in[CrcSpan + 2] = ~crc_ff[15:8];
         hdr_in[CrcSpan + 3] = ~crc_ff[7:0];
         idx_in = '0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.single) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = 8'd0;
         byte_index_in = 5'd0;
         last_in       = 1'b1;
         status_in     = cmd_status;
         flags_in      = (cmd_status == ST_OK) ? cur_flags : 4'd0;
      end

      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         out_byte_in   = hdr_ff[idx_ff];
         byte_index_in = idx_ff;
         last_in       = (idx_ff == IdxW'(HdrLen - 1));
         status_in     = ST_OK;
         flags_in      = cur_flags;
         idx_in        = idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         crc_ff       <= CRC_ONES;
         idx_ff       <= '0;
         max_pri_ff   <= PRI_RESET;
         max_tries_ff <= TRIES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         crc_ff       <= crc_in;
         idx_ff       <= idx_in;
         max_pri_ff   <= max_pri_in;
         max_tries_ff <= max_tries_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff        <= hdr_in;
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      out_byte_ff   <= out_byte_in;
      byte_index_ff <= byte_index_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      flags_ff      <= flags_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_byte        = out_byte_ff;
   assign rsp_byte_index      = byte_index_ff;
   assign rsp_last            = last_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot_a_bootable = flags_ff[0];
   assign rsp_slot_b_bootable = flags_ff[1];
   assign rsp_slot_a_illegal  = flags_ff[2];
   assign rsp_slot_b_illegal  = flags_ff[3];

endmodule

@@ src/abm_ctrl.sv @@
`timescale 1ns / 1ps

module abm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [2:0]            req_operation,
   output logic                  req_stall,
   output abm_pkg::abm_cmd_type  cmd,
   input  abm_pkg::abm_stat_type stat
);
   import abm_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_CRC,
      S_WRITE_CRC,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load = 1'b1;
               end else if (req_operation <= OP_DISABLE) begin
                  cmd.start = 1'b1;
                  state_in  = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (stat.single_needed) begin
               if (stat.out_free) begin
                  cmd.single = 1'b1;
                  state_in   = S_IDLE;
               end
            end else begin
               cmd.write_slots = 1'b1;
               state_in        = S_CRC;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            if (stat.crc_last) begin
               state_in = S_WRITE_CRC;
            end
         end
         S_WRITE_CRC: begin
            cmd.write_crc = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule
